/* rtl/rdm_pkg.sv */
// ----------------------------------------------------------------------------
// rdm_pkg
// Types, register map and fixed-point helpers for the radial distortion map.
// ----------------------------------------------------------------------------
package rdm_pkg;

  localparam int PIX_W      = 13;
  localparam int OUT_W      = 24;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int K_FRAC     = 20;

  localparam logic [17:0] FOCAL_RST = 18'd16000;
  localparam logic [31:0] INV_RST   = 32'd1073742;

  localparam logic signed [63:0] NORM_MAX = 64'sd2147483647;
  localparam logic signed [63:0] NORM_MIN = -64'sd2147483648;
  localparam logic signed [63:0] OUT_MAX  = 64'sd8388607;
  localparam logic signed [63:0] OUT_MIN  = -64'sd8388608;

  typedef enum logic [2:0] {
    REG_FOCAL    = 3'd0,
    REG_INV      = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_K1       = 3'd4,
    REG_K2       = 3'd5,
    REG_K3       = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [17:0]        focal_length;
    logic [31:0]        inv_focal;
    logic [16:0]        center_x;
    logic [16:0]        center_y;
    logic signed [23:0] coef_k1;
    logic signed [23:0] coef_k2;
    logic signed [23:0] coef_k3;
  } rdm_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
  } coord_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] dist_x;
    logic signed [OUT_W-1:0] dist_y;
    logic                    saturated;
  } dist_t;

  // round half up, then arithmetic shift right by s
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                             input int unsigned s);
    logic signed [63:0] half;
    half = 64'sd1 <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic logic ovf_norm(input logic signed [63:0] v);
    return (v > NORM_MAX) || (v < NORM_MIN);
  endfunction

  function automatic logic signed [31:0] sat_norm(input logic signed [63:0] v);
    logic signed [63:0] c;
    if (v > NORM_MAX) begin
      c = NORM_MAX;
    end else if (v < NORM_MIN) begin
      c = NORM_MIN;
    end else begin
      c = v;
    end
    return c[31:0];
  endfunction

  function automatic logic ovf_out(input logic signed [63:0] v);
    return (v > OUT_MAX) || (v < OUT_MIN);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    logic signed [63:0] c;
    if (v > OUT_MAX) begin
      c = OUT_MAX;
    end else if (v < OUT_MIN) begin
      c = OUT_MIN;
    end else begin
      c = v;
    end
    return c[OUT_W-1:0];
  endfunction

endpackage

/* rtl/rdm_regs.sv */
// ----------------------------------------------------------------------------
// rdm_regs
// APB register file holding focal, centre and coefficient settings.
// ----------------------------------------------------------------------------
module rdm_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rdm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [rdm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rdm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output rdm_pkg::rdm_cfg_t                  cfg
);
  import rdm_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_length <= FOCAL_RST;
      cfg.inv_focal    <= INV_RST;
      cfg.center_x     <= '0;
      cfg.center_y     <= '0;
      cfg.coef_k1      <= '0;
      cfg.coef_k2      <= '0;
      cfg.coef_k3      <= '0;
    end else if (wr) begin
      case (idx)
        REG_FOCAL:    cfg.focal_length <= pwdata[17:0];
        REG_INV:      cfg.inv_focal    <= pwdata[31:0];
        REG_CENTER_X: cfg.center_x     <= pwdata[16:0];
        REG_CENTER_Y: cfg.center_y     <= pwdata[16:0];
        REG_K1:       cfg.coef_k1      <= $signed(pwdata[23:0]);
        REG_K2:       cfg.coef_k2      <= $signed(pwdata[23:0]);
        REG_K3:       cfg.coef_k3      <= $signed(pwdata[23:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FOCAL:    prdata = 32'(cfg.focal_length);
      REG_INV:      prdata = cfg.inv_focal;
      REG_CENTER_X: prdata = 32'(cfg.center_x);
      REG_CENTER_Y: prdata = 32'(cfg.center_y);
      REG_K1:       prdata = 32'(unsigned'(cfg.coef_k1));
      REG_K2:       prdata = 32'(unsigned'(cfg.coef_k2));
      REG_K3:       prdata = 32'(unsigned'(cfg.coef_k3));
      default:      prdata = '0;
    endcase
  end

endmodule

/* rtl/radial_distortion_map_top.sv */
// ----------------------------------------------------------------------------
// radial_distortion_map_top
// Brown-Conrady radial lens distortion remap, one pixel per clock while dist_ready is high.
// ----------------------------------------------------------------------------
// Usage:
//   coord channel (coord_valid/coord_ready/coord) takes an output pixel
//   (column, row). dist channel (dist_valid/dist_ready/dist_data) returns the
//   distorted source position in signed Q16.8 and a saturation flag.
//   The user must write settings over the APB port only while no item is in flight; the block does not enforce this.
// Pipeline:
//   one item per cycle sustained while dist_ready is high. Fifteen register
//   stages: a centre subtraction, then alternating multiply and round and
//   saturate steps.
// Reset:
//   Registers return to their defaults and the pipeline empties.
// Stall:
//   A skid register catches the last stage's item when dist_ready is low;
//   the pipeline then holds and coord_ready drops until the skid drains.
//   No item is lost or repeated.
// ----------------------------------------------------------------------------
module radial_distortion_map_top #(
  parameter int COORD_BITS     = 13,
  parameter int NORM_FRAC_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           coord_valid,
  output logic                           coord_ready,
  input  rdm_pkg::coord_t                coord,
  output logic                           dist_valid,
  input  logic                           dist_ready,
  output rdm_pkg::dist_t                 dist_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rdm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rdm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rdm_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import rdm_pkg::*;

  localparam int NSTG = 15;
  localparam int XSH  = 34 - NORM_FRAC_BITS;
  localparam int FSH  = NORM_FRAC_BITS - 4;

  rdm_cfg_t cfg;

  rdm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [NSTG-1:0] v;
  logic            run;
  logic            skid_v;
  dist_t           skid;
  dist_t           res15;

  logic [PIX_W-1:0] col_m, row_m;

  logic signed [17:0] dx1, dy1;
  logic signed [50:0] px2, py2;
  logic signed [31:0] x3, y3;
  logic               f3;
  logic signed [63:0] xx4, yy4;
  logic signed [31:0] x4, y4;
  logic               f4;
  logic signed [31:0] r2_5, x5, y5;
  logic               f5;
  logic signed [63:0] r4p6;
  logic signed [31:0] r2_6, x6, y6;
  logic               f6;
  logic signed [31:0] r4_7, r2_7, x7, y7;
  logic               f7;
  logic signed [63:0] r6p8;
  logic signed [55:0] t1p8, t2p8;
  logic signed [31:0] x8, y8;
  logic               f8;
  logic signed [31:0] r6_9, x9, y9;
  logic signed [37:0] t12_9;
  logic               f9;
  logic signed [55:0] t3p10;
  logic signed [37:0] t12_10;
  logic signed [31:0] x10, y10;
  logic               f10;
  logic signed [31:0] dr11, x11, y11;
  logic               f11;
  logic signed [63:0] xdp12, ydp12;
  logic signed [31:0] x12, y12;
  logic               f12;
  logic signed [31:0] xd13, yd13;
  logic               f13;
  logic signed [50:0] xf14, yf14;
  logic               f14;

  logic signed [63:0] x_raw, y_raw, r2_raw, r4_raw, r6_raw, dr_raw;
  logic signed [63:0] xr_raw, yr_raw, xs_raw, ys_raw, ox_raw, oy_raw;
  logic signed [31:0] xr_sat, yr_sat;
  logic signed [63:0] cx16, cy16;

  always_comb begin
    for (int i = 0; i < PIX_W; i++) begin
      col_m[i] = (i < COORD_BITS) ? coord.pixel_col[i] : 1'b0;
      row_m[i] = (i < COORD_BITS) ? coord.pixel_row[i] : 1'b0;
    end
  end

  always_comb begin
    x_raw  = rnd(64'(px2), XSH);
    y_raw  = rnd(64'(py2), XSH);
    r2_raw = rnd(xx4, NORM_FRAC_BITS) + rnd(yy4, NORM_FRAC_BITS);
    r4_raw = rnd(r4p6, NORM_FRAC_BITS);
    r6_raw = rnd(r6p8, NORM_FRAC_BITS);
    dr_raw = 64'(t12_10) + rnd(64'(t3p10), K_FRAC);
    xr_raw = rnd(xdp12, NORM_FRAC_BITS);
    yr_raw = rnd(ydp12, NORM_FRAC_BITS);
    xr_sat = sat_norm(xr_raw);
    yr_sat = sat_norm(yr_raw);
    xs_raw = 64'(x12) + 64'(xr_sat);
    ys_raw = 64'(y12) + 64'(yr_sat);
    cx16   = $signed(64'({cfg.center_x, 4'b0000}));
    cy16   = $signed(64'({cfg.center_y, 4'b0000}));
    ox_raw = rnd(64'(xf14), FSH) + cx16;
    oy_raw = rnd(64'(yf14), FSH) + cy16;
  end

  assign run         = !skid_v;
  assign coord_ready = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (run) begin
      v <= {v[NSTG-2:0], coord_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      dx1    <= $signed({1'b0, col_m, 4'b0000}) - $signed({1'b0, cfg.center_x});
      dy1    <= $signed({1'b0, row_m, 4'b0000}) - $signed({1'b0, cfg.center_y});

      px2    <= dx1 * $signed({1'b0, cfg.inv_focal});
      py2    <= dy1 * $signed({1'b0, cfg.inv_focal});

      x3     <= sat_norm(x_raw);
      y3     <= sat_norm(y_raw);
      f3     <= ovf_norm(x_raw) | ovf_norm(y_raw);

      xx4    <= x3 * x3;
      yy4    <= y3 * y3;
      x4     <= x3;
      y4     <= y3;
      f4     <= f3;

      r2_5   <= sat_norm(r2_raw);
      x5     <= x4;
      y5     <= y4;
      f5     <= f4 | ovf_norm(r2_raw);

      r4p6   <= r2_5 * r2_5;
      r2_6   <= r2_5;
      x6     <= x5;
      y6     <= y5;
      f6     <= f5;

      r4_7   <= sat_norm(r4_raw);
      r2_7   <= r2_6;
      x7     <= x6;
      y7     <= y6;
      f7     <= f6 | ovf_norm(r4_raw);

      r6p8   <= r4_7 * r2_7;
      t1p8   <= cfg.coef_k1 * r2_7;
      t2p8   <= cfg.coef_k2 * r4_7;
      x8     <= x7;
      y8     <= y7;
      f8     <= f7;

      r6_9   <= sat_norm(r6_raw);
      t12_9  <= 38'(rnd(64'(t1p8), K_FRAC) + rnd(64'(t2p8), K_FRAC));
      x9     <= x8;
      y9     <= y8;
      f9     <= f8 | ovf_norm(r6_raw);

      t3p10  <= cfg.coef_k3 * r6_9;
      t12_10 <= t12_9;
      x10    <= x9;
      y10    <= y9;
      f10    <= f9;

      dr11   <= sat_norm(dr_raw);
      x11    <= x10;
      y11    <= y10;
      f11    <= f10 | ovf_norm(dr_raw);

      xdp12  <= x11 * dr11;
      ydp12  <= y11 * dr11;
      x12    <= x11;
      y12    <= y11;
      f12    <= f11;

      xd13   <= sat_norm(xs_raw);
      yd13   <= sat_norm(ys_raw);
      f13    <= f12 | ovf_norm(xr_raw) | ovf_norm(yr_raw)
                    | ovf_norm(xs_raw) | ovf_norm(ys_raw);

      xf14   <= xd13 * $signed({1'b0, cfg.focal_length});
      yf14   <= yd13 * $signed({1'b0, cfg.focal_length});
      f14    <= f13;

      res15.dist_x    <= sat_out(ox_raw);
      res15.dist_y    <= sat_out(oy_raw);
      res15.saturated <= f14 | ovf_out(ox_raw) | ovf_out(oy_raw);
    end
  end

  // catch the last item when the receiver stalls, hold the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (dist_ready) begin
        skid_v <= 1'b0;
      end
    end else if (v[NSTG-1] && !dist_ready) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v && v[NSTG-1] && !dist_ready) begin
      skid <= res15;
    end
  end

  assign dist_valid = skid_v || v[NSTG-1];
  assign dist_data  = skid_v ? skid : res15;

endmodule
